### hw/rtl/catmull_rom_path_follower_macros.svh
// Assertion helpers used by the path follower RTL.
`ifndef CATMULL_ROM_PATH_FOLLOWER_MACROS_SVH
`define CATMULL_ROM_PATH_FOLLOWER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CRPF_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define CRPF_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hw/rtl/crpf_pkg.sv
`default_nettype none

package crpf_pkg;

    localparam int IDX_W    = 7;
    localparam int SPEED_W  = 24;
    localparam int DT_W     = 24;
    localparam int COORD_W  = 32;
    localparam int DIR_W    = 16;
    localparam int FRAC_W   = 16;
    localparam int OPND_W   = 64;
    localparam int ROOT_W   = 32;
    localparam int QUO_W    = 46;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic CFG_POINT_COUNT  = 1'b0;
    localparam logic CFG_TRAVEL_SPEED = 1'b1;

    localparam logic [IDX_W-1:0]   POINT_COUNT_RST  = 7'd2;
    localparam logic [SPEED_W-1:0] TRAVEL_SPEED_RST = 24'd91750;

    typedef enum logic {
        DS_DIV  = 1'b0,
        DS_SQRT = 1'b1
    } ds_op_t;

    typedef struct packed {
        logic   start;
        ds_op_t op;
    } ds_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ds_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/crpf_divsqrt.sv
`default_nettype none

module crpf_divsqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire crpf_pkg::ds_req_t            req,
    input  wire logic [crpf_pkg::OPND_W-1:0]  num,
    input  wire logic [crpf_pkg::ROOT_W-1:0]  den,
    output crpf_pkg::ds_rsp_t                 rsp,
    output logic [crpf_pkg::QUO_W-1:0]        result
);

    localparam int DIV_STEPS  = crpf_pkg::QUO_W;
    localparam int SQRT_STEPS = crpf_pkg::OPND_W / 2;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int REM_W      = crpf_pkg::ROOT_W + 2;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    crpf_pkg::ds_op_t              op_reg, op_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [crpf_pkg::OPND_W-1:0]   opnd_reg, opnd_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [crpf_pkg::QUO_W-1:0]    res_reg, res_next;
    logic [crpf_pkg::ROOT_W-1:0]   den_reg, den_next;

    logic [REM_W-1:0]              shifted;
    logic [REM_W-1:0]              trial;
    logic [REM_W:0]                diff;
    logic                          ge;

    // one shared subtract/compare serves both the divide and the root step
    always_comb
    begin
        if (op_reg == crpf_pkg::DS_DIV)
        begin
            shifted = {rem_reg[REM_W-2:0], opnd_reg[crpf_pkg::OPND_W-1]};
            trial   = {2'b00, den_reg};
        end
        else
        begin
            shifted = {rem_reg[REM_W-3:0], opnd_reg[crpf_pkg::OPND_W-1 -: 2]};
            trial   = {res_reg[crpf_pkg::ROOT_W-1:0], 2'b01};
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = ~diff[REM_W];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        opnd_next = opnd_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            den_next  = den;
            rem_next  = '0;
            res_next  = '0;
            if (req.op == crpf_pkg::DS_DIV)
            begin
                opnd_next = {num[crpf_pkg::QUO_W-1:0],
                             {(crpf_pkg::OPND_W - crpf_pkg::QUO_W){1'b0}}};
                cnt_next  = CNT_W'(DIV_STEPS - 1);
            end
            else
            begin
                opnd_next = num;
                cnt_next  = CNT_W'(SQRT_STEPS - 1);
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[REM_W-1:0] : shifted;
            res_next = {res_reg[crpf_pkg::QUO_W-2:0], ge};
            if (op_reg == crpf_pkg::DS_DIV)
                opnd_next = {opnd_reg[crpf_pkg::OPND_W-2:0], 1'b0};
            else
                opnd_next = {opnd_reg[crpf_pkg::OPND_W-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= crpf_pkg::DS_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        den_reg  <= den_next;
    end

    assign rsp    = '{busy: busy_reg, done: done_reg};
    assign result = res_reg;

endmodule

`default_nettype wire

### hw/rtl/catmull_rom_path_follower.sv
// Catmull-Rom path follower. A load item (func 0) writes one control point into the
// point table. A tick item (func 1) advances the point along the path at travel_speed
// over tick_dt and returns position and unit tangent. A load, or a tick at the path
// end, goes straight to the output state, whose result is registered once the output
// register is free. A long tangent is halved step by step before its norm is taken,
// in the rate pass and in the direction pass. The time is set by the single
// bit-serial divide/root unit: up to two square roots and four divides per tick.
// Three four-point blends on one shared multiplier read the point table one slot
// per pass. The block takes no new item while a tick is in progress. A finished
// result waits in the output register while the next item is taken.
`default_nettype none
`include "catmull_rom_path_follower_macros.svh"

module catmull_rom_path_follower #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [23:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 func,
    input  wire logic [5:0]           point_index,
    input  wire logic signed [31:0]   point_x,
    input  wire logic signed [31:0]   point_y,
    input  wire logic signed [31:0]   point_z,
    input  wire logic [23:0]          tick_dt,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      moved,
    output logic                      at_end,
    output logic signed [31:0]        pos_x,
    output logic signed [31:0]        pos_y,
    output logic signed [31:0]        pos_z,
    output logic signed [15:0]        dir_x,
    output logic signed [15:0]        dir_y,
    output logic signed [15:0]        dir_z
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = (AW > crpf_pkg::IDX_W) ? AW : crpf_pkg::IDX_W;
    localparam int EW = SW + 1;
    localparam int PT_W  = 3 * crpf_pkg::COORD_W;
    localparam int W_W   = 24;
    localparam int MUL_W = 33;
    localparam int PRD_W = 2 * MUL_W;
    localparam int ACC_W = 60;
    localparam int G_W   = ACC_W - 17;
    localparam int R_W   = 31;
    localparam int SUM_W = 62;
    localparam int SH_W  = 4;

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_T2      = 19'h00002,
        S_T3      = 19'h00004,
        S_WGT     = 19'h00008,
        S_RD      = 19'h00010,
        S_MUL     = 19'h00020,
        S_ACC     = 19'h00040,
        S_POST    = 19'h00080,
        S_RED     = 19'h00100,
        S_SQ      = 19'h00200,
        S_SQACC   = 19'h00400,
        S_ROOT_GO = 19'h00800,
        S_ROOT    = 19'h01000,
        S_DIV_GO  = 19'h02000,
        S_DIV     = 19'h04000,
        S_INC     = 19'h08000,
        S_UPD     = 19'h10000,
        S_CHK     = 19'h20000,
        S_EMIT    = 19'h40000
    } state_t;

    typedef enum logic [2:0] {
        PH_RATE = 3'b001,
        PH_POS  = 3'b010,
        PH_DIR  = 3'b100
    } phase_t;

    state_t                     state_reg, state_next;
    phase_t                     phase_reg, phase_next;
    logic [crpf_pkg::IDX_W-1:0] pcount_reg, pcount_next;
    logic [23:0]                speed_reg, speed_next;
    logic [crpf_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]                frac_reg, frac_next;
    logic [1:0]                 kc_reg, kc_next;
    logic [1:0]                 c_reg, c_next;
    logic                       moved_reg, moved_next;
    logic                       out_valid_reg, out_valid_next;

    logic [23:0]                dt_reg, dt_next;
    logic [15:0]                t2_reg, t2_next;
    logic signed [W_W-1:0]      w_reg [4];
    logic signed [W_W-1:0]      w_next [4];
    logic signed [ACC_W-1:0]    acc_reg [3];
    logic signed [ACC_W-1:0]    acc_next [3];
    logic signed [G_W-1:0]      g_reg [3];
    logic signed [G_W-1:0]      g_next [3];
    logic [G_W-1:0]             m_reg, m_next;
    logic [SH_W-1:0]            sh_reg, sh_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [31:0]                rate_reg, rate_next;
    logic signed [PRD_W-1:0]    prod_reg, prod_next;
    logic signed [31:0]         pos_reg [3];
    logic signed [31:0]         pos_next [3];
    logic signed [15:0]         dir_reg [3];
    logic signed [15:0]         dir_next [3];
    logic                       moved_out_reg, moved_out_next;
    logic                       at_end_out_reg, at_end_out_next;
    logic signed [31:0]         pos_out_reg [3];
    logic signed [31:0]         pos_out_next [3];
    logic signed [15:0]         dir_out_reg [3];
    logic signed [15:0]         dir_out_next [3];

    logic [PT_W-1:0]            mem [MAX_POINTS];
    logic [PT_W-1:0]            mem_q_reg;

    logic                       in_xfer;
    logic                       wr_en;
    logic [EW-1:0]              pc_ext, max_ext, eff, last, idx_ext, pi_ext;
    logic [EW-1:0]              slot0, slot2, slot3, slot_sel;
    logic [AW-1:0]              rd_addr, wr_addr;
    logic                       at_end_now;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [W_W-1:0]      te, t2e, t3e;
    logic signed [31:0]         comp;
    logic signed [G_W-1:0]      g_new [3];
    logic [G_W-1:0]             g_abs [3];
    logic [G_W-1:0]             m_new;
    logic signed [R_W-1:0]      r_sel;
    logic [R_W-1:0]             r_mag;
    logic [39:0]                inc_full;
    logic [31:0]                inc;
    logic [32:0]                fsum;
    logic [crpf_pkg::QUO_W-1:0] q_sh;
    logic [14:0]                dmag;

    crpf_pkg::ds_req_t          ds_req;
    crpf_pkg::ds_rsp_t          ds_rsp;
    logic [crpf_pkg::OPND_W-1:0] ds_num;
    logic [crpf_pkg::QUO_W-1:0] ds_result;

    crpf_divsqrt u_divsqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ds_req),
        .num    (ds_num),
        .den    (rate_reg),
        .rsp    (ds_rsp),
        .result (ds_result)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;

    // path bookkeeping
    always_comb
    begin
        pc_ext   = EW'(pcount_reg);
        max_ext  = EW'(MAX_POINTS);
        eff      = (pc_ext > max_ext) ? max_ext : pc_ext;
        last     = eff - 1'b1;
        idx_ext  = EW'(idx_reg);
        pi_ext   = EW'(point_index);
        at_end_now = (idx_ext + 1'b1) >= eff;
        slot0    = (idx_reg == '0) ? '0 : idx_ext - 1'b1;
        slot2    = ((idx_ext + EW'(1)) > last) ? last : idx_ext + EW'(1);
        slot3    = ((idx_ext + EW'(2)) > last) ? last : idx_ext + EW'(2);
        case (kc_reg)
            2'd0:    slot_sel = slot0;
            2'd1:    slot_sel = idx_ext;
            2'd2:    slot_sel = slot2;
            default: slot_sel = slot3;
        endcase
        rd_addr  = slot_sel[AW-1:0];
        wr_addr  = pi_ext[AW-1:0];
        wr_en    = in_xfer && (func == crpf_pkg::FUNC_LOAD) && (pi_ext < max_ext);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {point_x, point_y, point_z};
        mem_q_reg <= mem[rd_addr];
    end

    // datapath helpers
    always_comb
    begin
        te  = W_W'(frac_reg);
        t2e = W_W'(t2_reg);
        t3e = W_W'(prod_reg[31:16]);
        case (c_reg)
            2'd0:    comp = mem_q_reg[95:64];
            2'd1:    comp = mem_q_reg[63:32];
            default: comp = mem_q_reg[31:0];
        endcase
        for (int i = 0; i < 3; i++)
        begin
            g_new[i] = G_W'(acc_reg[i] >>> 17);
            g_abs[i] = g_new[i][G_W-1] ? G_W'(-g_new[i]) : G_W'(g_new[i]);
        end
        m_new = (g_abs[0] > g_abs[1]) ? g_abs[0] : g_abs[1];
        if (g_abs[2] > m_new)
            m_new = g_abs[2];
        r_sel    = g_reg[c_reg][R_W-1:0];
        r_mag    = r_sel[R_W-1] ? R_W'(-r_sel) : R_W'(r_sel);
        inc_full = prod_reg[55:16];
        inc      = (inc_full[39:32] != '0) ? 32'hFFFF_FFFF : inc_full[31:0];
        fsum     = {1'b0, inc} + 33'(frac_reg);
        q_sh     = ds_result >> sh_reg;
        dmag     = (ds_result > crpf_pkg::QUO_W'(16384)) ? 15'd16384 : ds_result[14:0];
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pcount_next    = pcount_reg;
        speed_next     = speed_reg;
        idx_next       = idx_reg;
        frac_next      = frac_reg;
        kc_next        = kc_reg;
        c_next         = c_reg;
        moved_next     = moved_reg;
        out_valid_next = out_valid_reg;
        dt_next        = dt_reg;
        t2_next        = t2_reg;
        m_next         = m_reg;
        sh_next        = sh_reg;
        sum_next       = sum_reg;
        rate_next      = rate_reg;
        moved_out_next = moved_out_reg;
        at_end_out_next = at_end_out_reg;
        for (int i = 0; i < 4; i++)
            w_next[i] = w_reg[i];
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i]     = acc_reg[i];
            g_next[i]       = g_reg[i];
            pos_next[i]     = pos_reg[i];
            dir_next[i]     = dir_reg[i];
            pos_out_next[i] = pos_out_reg[i];
            dir_out_next[i] = dir_out_reg[i];
        end
        mul_a      = '0;
        mul_b      = '0;
        ds_req     = '{start: 1'b0, op: crpf_pkg::DS_DIV};
        ds_num     = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                crpf_pkg::CFG_POINT_COUNT:  pcount_next = cfg_data[crpf_pkg::IDX_W-1:0];
                crpf_pkg::CFG_TRAVEL_SPEED: speed_next  = cfg_data;
                default:                    speed_next  = speed_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dt_next = tick_dt;
                    moved_next = 1'b0;
                    if (func == crpf_pkg::FUNC_LOAD || at_end_now)
                        state_next = S_EMIT;
                    else
                    begin
                        phase_next = PH_RATE;
                        state_next = S_T2;
                    end
                end
            end
            S_T2:
            begin
                mul_a = MUL_W'(frac_reg);
                mul_b = MUL_W'(frac_reg);
                state_next = S_T3;
            end
            S_T3:
            begin
                t2_next = prod_reg[31:16];
                mul_a = MUL_W'(prod_reg[31:16]);
                mul_b = MUL_W'(frac_reg);
                state_next = S_WGT;
            end
            S_WGT:
            begin
                if (phase_reg == PH_POS)
                begin
                    w_next[0] = -t3e + (t2e <<< 1) - te;
                    w_next[1] = (t3e <<< 1) + t3e - (t2e <<< 2) - t2e + W_W'(131072);
                    w_next[2] = -(t3e <<< 1) - t3e + (t2e <<< 2) + te;
                    w_next[3] = t3e - t2e;
                end
                else
                begin
                    w_next[0] = -(t2e <<< 1) - t2e + (te <<< 2) - W_W'(65536);
                    w_next[1] = (t2e <<< 3) + t2e - (te <<< 3) - (te <<< 1);
                    w_next[2] = -(t2e <<< 3) - t2e + (te <<< 3) + W_W'(65536);
                    w_next[3] = (t2e <<< 1) + t2e - (te <<< 1);
                end
                for (int i = 0; i < 3; i++)
                    acc_next[i] = '0;
                kc_next = '0;
                c_next  = '0;
                state_next = S_RD;
            end
            S_RD:
                state_next = S_MUL;
            S_MUL:
            begin
                mul_a = MUL_W'(comp);
                mul_b = MUL_W'(w_reg[kc_reg]);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next[c_reg] = acc_reg[c_reg] + prod_reg[ACC_W-1:0];
                if (c_reg == 2'd2)
                begin
                    c_next = '0;
                    if (kc_reg == 2'd3)
                        state_next = S_POST;
                    else
                    begin
                        kc_next = kc_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_POST:
            begin
                if (phase_reg == PH_POS)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (g_new[i][G_W-1:31] != {(G_W-31){g_new[i][G_W-1]}})
                            pos_next[i] = g_new[i][G_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        else
                            pos_next[i] = g_new[i][31:0];
                    end
                    phase_next = PH_DIR;
                    state_next = S_T2;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        g_next[i] = g_new[i];
                    m_next  = m_new;
                    sh_next = '0;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                if (m_reg[G_W-1:30] != '0)
                begin
                    m_next  = m_reg >> 1;
                    sh_next = sh_reg + 1'b1;
                    for (int i = 0; i < 3; i++)
                        g_next[i] = g_reg[i] >>> 1;
                end
                else
                begin
                    c_next   = '0;
                    sum_next = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                mul_a = MUL_W'(r_sel);
                mul_b = MUL_W'(r_sel);
                state_next = S_SQACC;
            end
            S_SQACC:
            begin
                sum_next = sum_reg + prod_reg[SUM_W-1:0];
                if (c_reg == 2'd2)
                    state_next = S_ROOT_GO;
                else
                begin
                    c_next = c_reg + 1'b1;
                    state_next = S_SQ;
                end
            end
            S_ROOT_GO:
            begin
                ds_req = '{start: 1'b1, op: crpf_pkg::DS_SQRT};
                ds_num = crpf_pkg::OPND_W'(sum_reg);
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (ds_rsp.done)
                begin
                    // rate_reg holds the norm while the divides run
                    rate_next = ds_result[31:0];
                    c_next    = '0;
                    if (ds_result[31:0] == '0)
                    begin
                        if (phase_reg == PH_RATE)
                        begin
                            rate_next  = 32'hFFFF_FFFF;
                            state_next = S_INC;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                                dir_next[i] = '0;
                            moved_next = 1'b1;
                            state_next = S_EMIT;
                        end
                    end
                    else
                        state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                ds_req = '{start: 1'b1, op: crpf_pkg::DS_DIV};
                if (phase_reg == PH_RATE)
                    ds_num = {24'd0, speed_reg, 16'd0};
                else
                    ds_num = {19'd0, r_mag, 14'd0};
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (ds_rsp.done)
                begin
                    if (phase_reg == PH_RATE)
                    begin
                        rate_next = (q_sh[crpf_pkg::QUO_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                                       : q_sh[31:0];
                        state_next = S_INC;
                    end
                    else
                    begin
                        dir_next[c_reg] = r_sel[R_W-1] ? -16'(dmag) : 16'(dmag);
                        if (c_reg == 2'd2)
                        begin
                            moved_next = 1'b1;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            c_next = c_reg + 1'b1;
                            state_next = S_DIV_GO;
                        end
                    end
                end
            end
            S_INC:
            begin
                mul_a = MUL_W'(dt_reg);
                mul_b = MUL_W'(rate_reg);
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (fsum[32:16] != '0)
                    idx_next = idx_reg + 1'b1;
                frac_next = fsum[15:0];
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (at_end_now)
                begin
                    moved_next = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    phase_next = PH_POS;
                    state_next = S_T2;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    moved_out_next  = moved_reg;
                    at_end_out_next = at_end_now;
                    for (int i = 0; i < 3; i++)
                    begin
                        pos_out_next[i] = moved_reg ? pos_reg[i] : '0;
                        dir_out_next[i] = moved_reg ? dir_reg[i] : '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_RATE;
            pcount_reg    <= crpf_pkg::POINT_COUNT_RST;
            speed_reg     <= crpf_pkg::TRAVEL_SPEED_RST;
            idx_reg       <= '0;
            frac_reg      <= '0;
            kc_reg        <= '0;
            c_reg         <= '0;
            moved_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pcount_reg    <= pcount_next;
            speed_reg     <= speed_next;
            idx_reg       <= idx_next;
            frac_reg      <= frac_next;
            kc_reg        <= kc_next;
            c_reg         <= c_next;
            moved_reg     <= moved_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg         <= dt_next;
        t2_reg         <= t2_next;
        m_reg          <= m_next;
        sh_reg         <= sh_next;
        sum_reg        <= sum_next;
        rate_reg       <= rate_next;
        prod_reg       <= prod_next;
        moved_out_reg  <= moved_out_next;
        at_end_out_reg <= at_end_out_next;
        for (int i = 0; i < 4; i++)
            w_reg[i] <= w_next[i];
        for (int i = 0; i < 3; i++)
        begin
            acc_reg[i]     <= acc_next[i];
            g_reg[i]       <= g_next[i];
            pos_reg[i]     <= pos_next[i];
            dir_reg[i]     <= dir_next[i];
            pos_out_reg[i] <= pos_out_next[i];
            dir_out_reg[i] <= dir_out_next[i];
        end
    end

    assign out_valid = out_valid_reg;
    assign moved     = moved_out_reg;
    assign at_end    = at_end_out_reg;
    assign pos_x     = pos_out_reg[0];
    assign pos_y     = pos_out_reg[1];
    assign pos_z     = pos_out_reg[2];
    assign dir_x     = dir_out_reg[0];
    assign dir_y     = dir_out_reg[1];
    assign dir_z     = dir_out_reg[2];

    `CRPF_ASSERT(a_idle_unit_free, in_ready |-> !ds_rsp.busy, "divide/root unit busy while idle")
    `CRPF_ASSERT(a_moved_not_end, (out_valid && moved) |-> !at_end, "moved result at path end")
    `CRPF_ASSERT(a_done_in_wait, ds_rsp.done |-> (state_reg == S_ROOT || state_reg == S_DIV), "unit result outside a wait state")
    `CRPF_NEVER(a_frac_only_upd, (state_reg != S_UPD) && (frac_next != frac_reg), "fraction changed outside update")

endmodule

`default_nettype wire
